// File: sv/tdss_pkg.sv
// ----------------------------------------------------------------------------
// tdss_pkg: shared types and helpers for the two-digit seven-segment scanner
// Item and result structs, operation codes, glyph table and tens split.
// ----------------------------------------------------------------------------
`default_nettype none

package tdss_pkg;

    // Operation codes carried in the input item
    localparam logic [1:0] OP_TICK   = 2'd0;
    localparam logic [1:0] OP_CHARS  = 2'd1;
    localparam logic [1:0] OP_NUMBER = 2'd2;
    localparam logic [1:0] OP_CLOCK  = 2'd3;

    localparam logic [3:0] GLYPH_DASH  = 4'd10;
    localparam logic [3:0] GLYPH_BLANK = 4'd11;
    localparam logic [7:0] SEG_POINT   = 8'h80;

    localparam logic [7:0] LEFT_PATTERN_RESET  = 8'h0f;
    localparam logic [7:0] RIGHT_PATTERN_RESET = 8'hf0;

    // Reciprocal of ten, scaled by 2^11; exact for values below 128
    localparam logic [7:0] RECIP_TEN = 8'd205;

    typedef struct packed {
        logic [1:0] operation;
        logic [7:0] char_left;
        logic [7:0] char_right;
        logic [6:0] number;
        logic [3:0] hours;
        logic [6:0] minutes;
    } in_item_t;

    typedef struct packed {
        logic [7:0] segment_lines;
        logic       left_enable;
        logic       right_enable;
    } out_item_t;

    // Decoded action for the scan stage
    typedef struct packed {
        logic       tick;
        logic       load;
        logic [7:0] left;
        logic [7:0] right;
    } pat_upd_t;

    // Segment patterns a..g in bits 0..6; indices 11..15 are blank
    function automatic logic [7:0] glyph(input logic [3:0] idx);
        logic [7:0] g;
        unique case (idx)
            4'd0:    g = 8'h3f;
            4'd1:    g = 8'h06;
            4'd2:    g = 8'h5b;
            4'd3:    g = 8'h4f;
            4'd4:    g = 8'h66;
            4'd5:    g = 8'h6d;
            4'd6:    g = 8'h7d;
            4'd7:    g = 8'h07;
            4'd8:    g = 8'h7f;
            4'd9:    g = 8'h6f;
            4'd10:   g = 8'h40;
            default: g = 8'h00;
        endcase
        return g;
    endfunction

    // Tens of a 7-bit value (0..12)
    function automatic logic [3:0] tens_of(input logic [6:0] v);
        logic [14:0] prod;
        prod = {8'd0, v} * {7'd0, RECIP_TEN};
        return prod[14:11];
    endfunction

    // Units of a 7-bit value given its tens
    function automatic logic [3:0] units_of(input logic [6:0] v, input logic [3:0] q);
        logic [6:0] diff;
        diff = v - {q, 3'b000} - {2'b00, q, 1'b0};
        return diff[3:0];
    endfunction

endpackage

`default_nettype wire

// File: sv/two_digit_seven_segment_scanner.sv
// ----------------------------------------------------------------------------
// two_digit_seven_segment_scanner: multiplexed two-digit display driver
// Scans one segment of one digit per tick; write items load digit patterns.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake           Payload
//  s_        in         s_valid / s_ready   in_item_t  (operation and operands)
//  m_        out        m_valid / m_ready   out_item_t (segment and digit lines)
//
//  The result is registered: each accepted item sits in the input register
//  while decode and scan update feed the result register. One item per
//  cycle is sustained while m_ready stays high.
//  A stalled result holds the pipe; both stages keep their item.
//  aresetn is synchronous, active low; patterns reset to 0x0f and 0xf0.
// ----------------------------------------------------------------------------
`default_nettype none

module two_digit_seven_segment_scanner (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire tdss_pkg::in_item_t s_item,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output tdss_pkg::out_item_t     m_item
);
    import tdss_pkg::*;

    logic     take;
    logic     item_valid;
    in_item_t item;
    pat_upd_t upd;

    tdss_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    tdss_decode u_decode (
        .item (item),
        .upd  (upd)
    );

    tdss_scan u_scan (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (item_valid),
        .upd        (upd),
        .take       (take),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_item     (m_item)
    );

endmodule

`default_nettype wire

// File: sv/tdss_in_reg.sv
// ----------------------------------------------------------------------------
// tdss_in_reg: input register
// Holds one accepted item until the scan stage takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module tdss_in_reg (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire tdss_pkg::in_item_t s_item,
    input  wire logic               take,
    output logic                    item_valid,
    output tdss_pkg::in_item_t      item
);
    import tdss_pkg::*;

    logic     valid_reg;
    in_item_t item_reg;

    // Free when empty or when the held item leaves this cycle
    assign s_ready    = !valid_reg || take;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    // Payload needs no reset
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

endmodule

`default_nettype wire

// File: sv/tdss_decode.sv
// ----------------------------------------------------------------------------
// tdss_decode: pattern decoder
// Turns a held item into a tick flag or a pair of new digit patterns.
// ----------------------------------------------------------------------------
`default_nettype none

module tdss_decode (
    input  wire tdss_pkg::in_item_t item,
    output tdss_pkg::pat_upd_t      upd
);
    import tdss_pkg::*;

    logic [6:0] num_val;
    logic [3:0] num_tens;
    logic [3:0] num_units;
    logic [7:0] num_left;
    logic [7:0] num_right;

    function automatic logic [7:0] char_glyph(input logic [7:0] c);
        logic [7:0] g;
        logic [7:0] off;
        off = c - 8'h30;
        if (c >= 8'h30 && c <= 8'h39) begin
            g = glyph(off[3:0]);
        end else if (c == 8'h2d) begin
            g = glyph(GLYPH_DASH);
        end else begin
            g = glyph(GLYPH_BLANK);
        end
        return g;
    endfunction

    // Shared number split; clock mode reuses it for the minutes
    assign num_val   = (item.operation == OP_NUMBER) ? item.number : item.minutes;
    assign num_tens  = tens_of(num_val);
    assign num_units = units_of(num_val, num_tens);
    assign num_left  = (num_val >= 7'd10) ? glyph(num_tens) : glyph(GLYPH_BLANK);
    assign num_right = glyph(num_units);

    always_comb begin
        upd = '0;
        unique case (item.operation)
            OP_TICK: begin
                upd.tick = 1'b1;
            end
            OP_CHARS: begin
                upd.load  = 1'b1;
                upd.left  = char_glyph(item.char_left);
                upd.right = char_glyph(item.char_right);
            end
            OP_NUMBER: begin
                upd.load  = 1'b1;
                upd.left  = num_left;
                upd.right = num_right;
            end
            default: begin
                upd.load = 1'b1;
                // nonzero hours: hours digit with point, then tens of minutes only; else minutes with point
                if (item.hours != 4'd0) begin
                    upd.left  = glyph(item.hours) | SEG_POINT;
                    upd.right = glyph(num_tens);
                end else begin
                    upd.left  = num_left;
                    upd.right = num_right | SEG_POINT;
                end
            end
        endcase
    end

endmodule

`default_nettype wire

// File: sv/tdss_scan.sv
// ----------------------------------------------------------------------------
// tdss_scan: scan state and result register
// Advances the scan count, drives segment and digit lines, holds the result.
// ----------------------------------------------------------------------------
`default_nettype none

module tdss_scan (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               item_valid,
    input  wire tdss_pkg::pat_upd_t upd,
    output logic                    take,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output tdss_pkg::out_item_t     m_item
);
    import tdss_pkg::*;

    logic [3:0]  scan_count_reg,  scan_count_next;
    logic [7:0]  left_pat_reg,    left_pat_next;
    logic [7:0]  right_pat_reg,   right_pat_next;
    logic [7:0]  drive_reg,       drive_next;
    logic        left_sel_reg,    left_sel_next;
    logic        right_sel_reg,   right_sel_next;
    logic        m_valid_reg;
    out_item_t   m_item_reg,      m_item_next;

    logic [3:0]  scan_count_inc;
    logic [2:0]  seg;
    logic        digit;
    logic [7:0]  cur_pat;

    // Move an item whenever the result slot is free or being drained
    assign take = item_valid && (!m_valid_reg || m_ready);

    assign scan_count_inc = scan_count_reg + 4'd1;
    assign seg     = scan_count_inc[2:0];
    assign digit   = scan_count_inc[3];
    assign cur_pat = digit ? right_pat_reg : left_pat_reg;

    // Next state of the scanner for the held item
    always_comb begin
        scan_count_next = scan_count_reg;
        left_pat_next   = left_pat_reg;
        right_pat_next  = right_pat_reg;
        drive_next      = drive_reg;
        left_sel_next   = left_sel_reg;
        right_sel_next  = right_sel_reg;
        if (upd.tick) begin
            scan_count_next = scan_count_inc;
            drive_next      = drive_reg & ~(8'd1 << scan_count_reg[2:0]);
            if (seg == 3'd0) begin
                left_sel_next  = !digit;
                right_sel_next = digit;
            end
            if (cur_pat[seg]) begin
                drive_next = drive_next | (8'd1 << seg);
            end
        end
        if (upd.load) begin
            left_pat_next  = upd.left;
            right_pat_next = upd.right;
        end
        m_item_next.segment_lines = drive_next;
        m_item_next.left_enable   = left_sel_next;
        m_item_next.right_enable  = right_sel_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_count_reg <= 4'd0;
            left_pat_reg   <= LEFT_PATTERN_RESET;
            right_pat_reg  <= RIGHT_PATTERN_RESET;
            drive_reg      <= 8'd0;
            left_sel_reg   <= 1'b0;
            right_sel_reg  <= 1'b0;
        end else if (take) begin
            scan_count_reg <= scan_count_next;
            left_pat_reg   <= left_pat_next;
            right_pat_reg  <= right_pat_next;
            drive_reg      <= drive_next;
            left_sel_reg   <= left_sel_next;
            right_sel_reg  <= right_sel_next;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (take) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            m_item_reg <= m_item_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

endmodule

`default_nettype wire

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for two_digit_seven_segment_scanner
// Streams ticks and pattern writes through the valid/ready input channel,
// tracks the scan count, digit patterns and select lines in a local display
// model, and checks every result transfer field by field in order.
// ----------------------------------------------------------------------------
module testbench;
    import tdss_pkg::*;

    typedef struct packed {
        in_item_t item;
        logic     drain;
    } queued_item_t;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_item = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_item;

    queued_item_t pending_items[$];
    out_item_t    expected_lines[$];
    int           accepted_count = 0;
    int           error_count = 0;
    bit           quiet;
    bit           hold_for_drain;
    bit           sender_idle;

    // Display model state
    logic [3:0] scan_cnt = '0;
    logic [7:0] left_pattern = LEFT_PATTERN_RESET;
    logic [7:0] right_pattern = RIGHT_PATTERN_RESET;
    logic [7:0] lit_segments = '0;
    logic       left_sel = 1'b0;
    logic       right_sel = 1'b0;

    two_digit_seven_segment_scanner DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    always #5 aclk = ~aclk;

    // Segment font a..g in bits 0..6; codes past the dash are dark
    function automatic logic [7:0] seg_font(input logic [3:0] code);
        case (code)
            4'd0:    return 8'h3f;
            4'd1:    return 8'h06;
            4'd2:    return 8'h5b;
            4'd3:    return 8'h4f;
            4'd4:    return 8'h66;
            4'd5:    return 8'h6d;
            4'd6:    return 8'h7d;
            4'd7:    return 8'h07;
            4'd8:    return 8'h7f;
            4'd9:    return 8'h6f;
            GLYPH_DASH: return 8'h40;
            default: return 8'h00;
        endcase
    endfunction

    // Anything but a digit or dash shows dark, a space included
    function automatic logic [7:0] char_font(input logic [7:0] c);
        if (c >= "0" && c <= "9") begin
            return seg_font(4'(c - "0"));
        end else if (c == "-") begin
            return seg_font(GLYPH_DASH);
        end
        return seg_font(GLYPH_BLANK);
    endfunction

    // Two-digit value, tens dark below ten; tens of 10..12 go through the font
    task automatic load_number(input logic [6:0] v);
        left_pattern = (v >= 7'd10) ? seg_font(4'(v / 10)) : seg_font(GLYPH_BLANK);
        right_pattern = seg_font(4'(v % 10));
    endtask

    // Update the display model with one accepted transfer and queue the result
    task automatic display_update(input in_item_t it);
        logic [2:0] seg;
        logic [7:0] pat;
        out_item_t  res;
        case (it.operation)
            OP_TICK: begin
                lit_segments[scan_cnt[2:0]] = 1'b0;
                scan_cnt = scan_cnt + 4'd1;
                seg = scan_cnt[2:0];
                if (seg == 3'd0) begin
                    left_sel = ~scan_cnt[3];
                    right_sel = scan_cnt[3];
                end
                pat = scan_cnt[3] ? right_pattern : left_pattern;
                if (pat[seg]) begin
                    lit_segments[seg] = 1'b1;
                end
            end
            OP_CHARS: begin
                left_pattern = char_font(it.char_left);
                right_pattern = char_font(it.char_right);
            end
            OP_NUMBER: begin
                load_number(it.number);
            end
            default: begin
                if (it.hours != 4'd0) begin
                    left_pattern = seg_font(it.hours) | SEG_POINT;
                    right_pattern = seg_font(4'(it.minutes / 10));
                end else begin
                    load_number(it.minutes);
                    right_pattern = right_pattern | SEG_POINT;
                end
            end
        endcase
        res.segment_lines = lit_segments;
        res.left_enable = left_sel;
        res.right_enable = right_sel;
        expected_lines.push_back(res);
    endtask

    // Item with every field random, then given the chosen operation
    function automatic in_item_t noise_item(input logic [1:0] op);
        in_item_t it;
        it.operation = op;
        it.char_left = 8'($urandom);
        it.char_right = 8'($urandom);
        it.number = 7'($urandom);
        it.hours = 4'($urandom);
        it.minutes = 7'($urandom);
        return it;
    endfunction

    function automatic logic [7:0] pick_char();
        case ($urandom_range(9))
            0, 1, 2, 3, 4, 5: return 8'("0" + $urandom_range(9));
            6: return "-";
            7: return " ";
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    function automatic logic [6:0] pick_value();
        if ($urandom_range(9) < 8) begin
            return 7'($urandom_range(99));
        end
        return 7'($urandom_range(127, 100));
    endfunction

    task automatic queue_item(input in_item_t it, input logic drain);
        queued_item_t q;
        q.item = it;
        q.drain = drain;
        pending_items.push_back(q);
    endtask

    task automatic queue_write(input logic [1:0] op, input logic [7:0] cl, input logic [7:0] cr,
                               input logic [6:0] num, input logic [3:0] hr,
                               input logic [6:0] mn);
        in_item_t it;
        it = noise_item(op);
        it.char_left = cl;
        it.char_right = cr;
        it.number = num;
        it.hours = hr;
        it.minutes = mn;
        queue_item(it, 1'b0);
    endtask

    task automatic queue_tick();
        queue_item(noise_item(OP_TICK), 1'b0);
    endtask

    // No idling on either side while this window of transfers passes
    assign quiet = (accepted_count >= 600) && (accepted_count < 900);

    // Input driver and display model update on each accepted transfer
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                display_update(s_item);
                accepted_count = accepted_count + 1;
            end
            if (!s_valid || s_ready) begin
                hold_for_drain = pending_items.size() != 0 && pending_items[0].drain &&
                                 expected_lines.size() != 0;
                sender_idle = !quiet && ($urandom_range(99) < 13);
                if (pending_items.size() != 0 && !hold_for_drain && !sender_idle) begin
                    s_valid <= 1'b1;
                    s_item <= pending_items[0].item;
                    pending_items.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor and random backpressure
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_lines.size() == 0) begin
                    $display("%0t: result transfer with nothing expected: actual %h",
                             $realtime, m_item);
                    error_count = error_count + 1;
                end else begin
                    if (m_item.segment_lines !== expected_lines[0].segment_lines) begin
                        $display("%0t: segment_lines expected %h actual %h", $realtime,
                                 expected_lines[0].segment_lines, m_item.segment_lines);
                        error_count = error_count + 1;
                    end
                    if (m_item.left_enable !== expected_lines[0].left_enable) begin
                        $display("%0t: left_enable expected %b actual %b", $realtime,
                                 expected_lines[0].left_enable, m_item.left_enable);
                        error_count = error_count + 1;
                    end
                    if (m_item.right_enable !== expected_lines[0].right_enable) begin
                        $display("%0t: right_enable expected %b actual %b", $realtime,
                                 expected_lines[0].right_enable, m_item.right_enable);
                        error_count = error_count + 1;
                    end
                    expected_lines.pop_front();
                end
            end
            m_ready <= quiet || ($urandom_range(99) >= 13);
        end
    end

    // Run limit
    initial begin
        #2000000;
        $display("two_digit_seven_segment_scanner verification failed");
        $finish;
    end

    // Stimulus, reset and end of run
    initial begin
        int n;
        int ticks;
        int k;
        logic [1:0] op;

        // Directed: reset patterns, character extremes, number and clock cases
        queue_tick();
        queue_write(OP_CHARS, "0", "9", 7'd0, 4'd0, 7'd0);
        queue_tick();
        queue_write(OP_CHARS, "-", " ", 7'd127, 4'd15, 7'd127);
        queue_tick();
        queue_write(OP_CHARS, 8'h00, 8'hff, 7'd0, 4'd0, 7'd0);
        queue_tick();
        queue_write(OP_CHARS, "/", ":", 7'd0, 4'd0, 7'd0);
        queue_write(OP_CHARS, "A", ",", 7'd0, 4'd0, 7'd0);
        queue_tick();
        queue_write(OP_NUMBER, 8'h00, 8'h00, 7'd0, 4'd0, 7'd0);
        queue_tick();
        queue_write(OP_NUMBER, 8'h00, 8'h00, 7'd9, 4'd0, 7'd0);
        queue_write(OP_NUMBER, 8'h00, 8'h00, 7'd10, 4'd0, 7'd0);
        queue_write(OP_NUMBER, 8'h00, 8'h00, 7'd99, 4'd0, 7'd0);
        queue_tick();
        queue_write(OP_NUMBER, 8'hff, 8'hff, 7'd100, 4'd0, 7'd0);
        queue_write(OP_NUMBER, 8'hff, 8'hff, 7'd110, 4'd0, 7'd0);
        queue_write(OP_NUMBER, 8'hff, 8'hff, 7'd127, 4'd0, 7'd0);
        queue_tick();
        queue_write(OP_CLOCK, 8'h00, 8'h00, 7'd0, 4'd0, 7'd0);
        queue_write(OP_CLOCK, 8'h00, 8'h00, 7'd0, 4'd0, 7'd127);
        queue_tick();
        queue_write(OP_CLOCK, 8'h00, 8'h00, 7'd0, 4'd9, 7'd59);
        queue_write(OP_CLOCK, 8'h00, 8'h00, 7'd0, 4'd10, 7'd5);
        queue_write(OP_CLOCK, 8'h00, 8'h00, 7'd0, 4'd15, 7'd127);
        queue_tick();

        // Random: pattern writes followed by scan runs, plus raw noise
        n = pending_items.size();
        while (n < 1400) begin
            if ($urandom_range(9) < 8) begin
                op = 2'($urandom_range(3, 1));
                if ($urandom_range(3) == 0) begin
                    queue_write(op, pick_char(), pick_char(), pick_value(),
                                4'($urandom_range(15)), pick_value());
                end else begin
                    queue_write(op, pick_char(), pick_char(), pick_value(),
                                ($urandom_range(2) == 0) ? 4'd0 : 4'($urandom_range(9)),
                                pick_value());
                end
                ticks = $urandom_range(20, 1);
                for (k = 0; k < ticks; k++) begin
                    queue_tick();
                end
                n = n + 1 + ticks;
            end else begin
                queue_item(noise_item(2'($urandom)), 1'b0);
                n = n + 1;
            end
        end
        // Sender waits for all results at a couple of points
        pending_items[400].drain = 1'b1;
        pending_items[1000].drain = 1'b1;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_items.size() != 0 || s_valid || expected_lines.size() != 0) begin
            @(posedge aclk);
        end
        repeat (10) @(posedge aclk);

        if (error_count == 0) begin
            $display("two_digit_seven_segment_scanner verification clean");
        end else begin
            $display("two_digit_seven_segment_scanner verification failed");
        end
        $finish;
    end

endmodule
